### rtl/kls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kls_pkg;

  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic cmp_en;
    logic occupied;
    logic load;
    logic shift;
  } kls_cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/kls_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface kls_req_if import kls_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, cmd, key, input ready);
  modport sink (input valid, cmd, key, output ready);
endinterface

interface kls_rsp_if import kls_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [CNT_W-1:0]  entry_count;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, status, position, entry_count, is_empty, is_full,
                  input ready);
  modport sink (input valid, status, position, entry_count, is_empty, is_full,
                output ready);
endinterface
`default_nettype wire

### rtl/kls_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module kls_cell import kls_pkg::*; (
  input  wire                  clk,
  input  wire kls_cell_ctrl_t  ctrl,
  input  wire [KEY_W-1:0]      cmp_key,
  input  wire [KEY_W-1:0]      new_key,
  input  wire [KEY_W-1:0]      nbr_key,
  output logic [KEY_W-1:0]     key,
  output logic                 hit
);

  // load appends at the tail, shift pulls the upper neighbor down on removal
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key <= new_key;
    end else if (ctrl.shift) begin
      key <= nbr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      hit <= ctrl.occupied && (key == cmp_key);
    end
  end

endmodule
`default_nettype wire

### rtl/keyed_sequential_list.sv
`timescale 1ns / 1ps
`default_nettype none
// Table of up to CAPACITY unique 32-bit keys kept packed in insertion order.
// Each request inserts, removes or looks up one key and yields exactly one
// response with status, position and the resulting fill state. Every entry
// sits in its own cell with its own comparator: a request passes a compare
// state, in which all cells compare against the key at once, then a resolve
// state, in which the match is resolved and the table updated (a removal
// moves every later entry down one place in the same update). A new request
// is taken when idle or as the resolve state finishes, which waits until the
// response register is drained. No clearing pass is needed after reset.
module keyed_sequential_list import kls_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  wire        clk,
  input  wire        rst,
  kls_req_if.sink    req,
  kls_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CMD_W-1:0]  cmd_q;
  logic [KEY_W-1:0]  key_q;

  logic [KEY_W-1:0]  cell_key [CAPACITY];
  logic [CAPACITY-1:0] hit;

  logic              out_free;
  logic              accept;
  logic              finish;
  logic              hit_any;
  logic [IW-1:0]     hit_idx;
  logic [CW-1:0]     hit_idx_ext;
  logic              tbl_full;
  logic [STAT_W-1:0] status_d;
  logic [IW-1:0]     pos_d;
  logic              do_ins;
  logic              do_rem;
  logic [CW+7:0]     cnt_wide;
  logic [IW+6:0]     pos_wide;

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) || ((state == S_RES) && out_free);
  assign accept    = req.valid && req.ready;
  assign finish    = (state == S_RES) && out_free;
  assign tbl_full  = (count == CW'(CAPACITY));

  // keys are unique, so at most one cell hits and an or-reduction encodes it
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign hit_any     = |hit;
  assign hit_idx_ext = CW'(hit_idx);

  always_comb begin
    status_d   = ST_ABSENT;
    pos_d      = '0;
    count_next = count;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    case (cmd_q)
      CMD_INSERT: begin
        if (tbl_full) begin
          status_d = ST_FULL;
        end else if (hit_any) begin
          status_d = ST_DUP;
        end else begin
          status_d   = ST_OK;
          pos_d      = count[IW-1:0];
          count_next = count + CW'(1);
          do_ins     = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit_any) begin
          status_d   = ST_OK;
          pos_d      = hit_idx;
          count_next = count - CW'(1);
          do_rem     = 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (hit_any) begin
          status_d = ST_OK;
          pos_d    = hit_idx;
        end
      end
      default: begin
        status_d = ST_ABSENT;
      end
    endcase
  end

  assign cnt_wide = {8'd0, count_next};
  assign pos_wide = {7'd0, pos_d};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_RES;
      end
      S_RES: begin
        if (accept) begin
          state_next = S_CMP;
        end else if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.cmd;
      key_q <= req.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.status      <= status_d;
      rsp.position    <= pos_wide[POS_W-1:0];
      rsp.entry_count <= cnt_wide[CNT_W-1:0];
      rsp.is_empty    <= (count_next == '0);
      rsp.is_full     <= (count_next == CW'(CAPACITY));
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kls_cell_ctrl_t   ctrl;
    logic [KEY_W-1:0] nbr;

    assign ctrl.cmp_en   = (state == S_CMP);
    assign ctrl.occupied = (CW'(i) < count);
    assign ctrl.load     = finish && do_ins && (CW'(i) == count);
    assign ctrl.shift    = finish && do_rem && (CW'(i) >= hit_idx_ext)
                           && (CW'(i + 1) < count);

    if (i == CAPACITY - 1) begin : g_last
      assign nbr = cell_key[i];
    end else begin : g_mid
      assign nbr = cell_key[i + 1];
    end

    kls_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .cmp_key (key_q),
      .new_key (key_q),
      .nbr_key (nbr),
      .key     (cell_key[i]),
      .hit     (hit[i])
    );
  end

endmodule
`default_nettype wire

### rtl/kls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module kls_checker import kls_pkg::*; (
  input wire              clk,
  input wire              rst,
  input wire              req_valid,
  input wire              req_ready,
  input wire              rsp_valid,
  input wire              rsp_ready,
  input wire [STAT_W-1:0] status,
  input wire [POS_W-1:0]  position,
  input wire [CNT_W-1:0]  entry_count,
  input wire              is_empty,
  input wire              is_full
);

  // one request in flight: the compare cycle never takes a request
  a_no_accept_in_compare: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken during compare cycle");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(position)
      && $stable(entry_count) && $stable(is_empty) && $stable(is_full))
    else $error("stalled response changed");

  a_rsp_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // a full report leaves the table full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> is_full && !is_empty)
    else $error("full status without full table");

  a_failed_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) && $rose(rsp_valid) |-> (position == '0))
    else $error("position set on failed request");

endmodule

bind keyed_sequential_list kls_checker u_kls_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .position    (rsp.position),
  .entry_count (rsp.entry_count),
  .is_empty    (rsp.is_empty),
  .is_full     (rsp.is_full)
);
`default_nettype wire
